### rtl/tilt_complementary_filter_assert.svh
// Assertion macros for the tilt filter
`ifndef TILT_COMPLEMENTARY_FILTER_ASSERT_SVH
`define TILT_COMPLEMENTARY_FILTER_ASSERT_SVH

// same-cycle implication
`define TCF_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tilt filter assertion failed");

// next-cycle implication
`define TCF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tilt filter assertion failed");

`endif

### rtl/tcf_pkg.sv
// ----------------------------------------------------------------------------
// tcf_pkg
// Shared types, codes and the arctangent table of the tilt filter.
// ----------------------------------------------------------------------------
package tcf_pkg;

    localparam int IN_W      = 16;
    localparam int TILT_W    = 15;
    localparam int ANG_W     = 16;
    localparam int DIR_W     = 3;
    localparam int ACC_W     = 48;
    localparam int CFG_W     = 25;
    localparam int OUT_TDATA_W = 104;
    localparam int SQRT_STEPS = 20;
    localparam int TAB_LEN   = 24;
    localparam int CNT_W     = 5;

    // register indexes
    localparam logic [1:0] REG_BLEND_WEIGHT   = 2'd0;
    localparam logic [1:0] REG_GYRO_GAIN      = 2'd1;
    localparam logic [1:0] REG_TILT_THRESHOLD = 2'd2;

    // direction codes
    localparam logic [DIR_W-1:0] DIR_NONE  = 3'd0;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd1;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd2;
    localparam logic [DIR_W-1:0] DIR_UP    = 3'd3;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd4;

    // datapath operations
    localparam logic [3:0] OP_NOP         = 4'd0;
    localparam logic [3:0] OP_LOAD        = 4'd1;
    localparam logic [3:0] OP_ACC         = 4'd2;
    localparam logic [3:0] OP_SQRT_INIT   = 4'd3;
    localparam logic [3:0] OP_SQRT_STEP   = 4'd4;
    localparam logic [3:0] OP_CORDIC_INIT = 4'd5;
    localparam logic [3:0] OP_CORDIC_STEP = 4'd6;
    localparam logic [3:0] OP_ANGLE       = 4'd7;
    localparam logic [3:0] OP_BLEND_MUL   = 4'd8;
    localparam logic [3:0] OP_BLEND_SUM   = 4'd9;
    localparam logic [3:0] OP_BLEND_SAT   = 4'd10;
    localparam logic [3:0] OP_COMMIT      = 4'd11;

    typedef struct packed {
        logic [3:0]       op;
        logic [1:0]       axis;
        logic [CNT_W-1:0] iter;
    } cmd_t;

    // atan(2^-i) in 2^-16 hundredths of a degree
    function automatic logic [29:0] atan_entry(input logic [CNT_W-1:0] i);
        logic [29:0] v;
        case (i)
            5'd0:  v = 30'd294912000;
            5'd1:  v = 30'd174096719;
            5'd2:  v = 30'd91987925;
            5'd3:  v = 30'd46694507;
            5'd4:  v = 30'd23437865;
            5'd5:  v = 30'd11730358;
            5'd6:  v = 30'd5866610;
            5'd7:  v = 30'd2933484;
            5'd8:  v = 30'd1466764;
            5'd9:  v = 30'd733385;
            5'd10: v = 30'd366693;
            5'd11: v = 30'd183346;
            5'd12: v = 30'd91673;
            5'd13: v = 30'd45837;
            5'd14: v = 30'd22918;
            5'd15: v = 30'd11459;
            5'd16: v = 30'd5730;
            5'd17: v = 30'd2865;
            5'd18: v = 30'd1432;
            5'd19: v = 30'd716;
            5'd20: v = 30'd358;
            5'd21: v = 30'd179;
            5'd22: v = 30'd90;
            5'd23: v = 30'd45;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

### rtl/tilt_complementary_filter.sv
// ----------------------------------------------------------------------------
// tilt_complementary_filter
// Accelerometer tilt angles blended with integrated gyro rates, plus a
// held direction code from roll and pitch.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one beat is one six-axis sample (accel x/y/z, gyro x/y/z,
//   Q8.8). m_ channel: one beat per sample with the three tilt angles,
//   blended roll/pitch/yaw, direction code and a changed flag.
//   cfg_ port: single-cycle writes of blend weight, gyro gain and tilt
//   threshold; write only while no sample is in flight.
//   Each axis runs a bitwise square root and then S CORDIC iterations,
//   S = min(CORDIC_STEPS, 24), on one shared unit, so samples are taken
//   one at a time: a new sample is accepted only after the last one has
//   been committed to the output register.
//   s_tready is high while the sequencer is idle, including while a result
//   still sits in the output register. If the receiver stalls, the next
//   sample is processed and waits at the end until the output register is
//   free; m_tdata holds while m_tvalid is high.
//   Reset clears the gyro accumulators, the held direction (none) and
//   loads the register defaults.
// ----------------------------------------------------------------------------
module tilt_complementary_filter #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z (16 bits each)
    input  logic [95:0]                      s_tdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // tilt_x, tilt_y, tilt_z (15 each), roll, pitch, yaw (16 each),
    // direction (3), direction_changed (1), zero pad (7)
    output logic [tcf_pkg::OUT_TDATA_W-1:0]  m_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic                             cfg_we,
    input  logic [1:0]                       cfg_addr,
    input  logic [tcf_pkg::CFG_W-1:0]        cfg_wdata
);

    tcf_pkg::cmd_t cmd;
    logic          out_changed;
    logic          out_no_dir;

    assign out_changed = m_tdata[96];
    assign out_no_dir  = (m_tdata[95:93] == tcf_pkg::DIR_NONE);

    tcf_ctrl #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    tcf_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .m_tdata   (m_tdata)
    );

`include "tilt_complementary_filter_assert.svh"

    // a taken sample leaves the sequencer busy
    `TCF_ASSERT_NEXT(a_busy_after_beat, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    // no result can appear right after a beat is taken
    `TCF_ASSERT_NEXT(a_no_instant_result, aclk, aresetn, s_tvalid && s_tready, !$rose(m_tvalid))
    // a change always lands on a real direction
    `TCF_ASSERT_IMPLY(a_change_has_dir, aclk, aresetn, m_tvalid && out_changed, !out_no_dir)

endmodule

### rtl/tcf_ctrl.sv
// ----------------------------------------------------------------------------
// tcf_ctrl
// Sequencer: walks one sample through load, accumulate, square root,
// CORDIC, angle, blend and commit, and owns both handshakes.
// ----------------------------------------------------------------------------
module tcf_ctrl #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    output tcf_pkg::cmd_t cmd
);

    localparam int STEPS_RUN = (CORDIC_STEPS > tcf_pkg::TAB_LEN) ?
                               tcf_pkg::TAB_LEN : CORDIC_STEPS;
    localparam logic [tcf_pkg::CNT_W-1:0] CO_LAST = tcf_pkg::CNT_W'(STEPS_RUN - 1);
    localparam logic [tcf_pkg::CNT_W-1:0] SQ_LAST =
        tcf_pkg::CNT_W'(tcf_pkg::SQRT_STEPS - 1);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_ACC     = 4'd1;
    localparam logic [3:0] S_SQ_INIT = 4'd2;
    localparam logic [3:0] S_SQ      = 4'd3;
    localparam logic [3:0] S_CO_INIT = 4'd4;
    localparam logic [3:0] S_CO      = 4'd5;
    localparam logic [3:0] S_ANGLE   = 4'd6;
    localparam logic [3:0] S_BL_MUL  = 4'd7;
    localparam logic [3:0] S_BL_SUM  = 4'd8;
    localparam logic [3:0] S_BL_SAT  = 4'd9;
    localparam logic [3:0] S_OUT     = 4'd10;

    logic [3:0]                state_reg, state_next;
    logic [1:0]                axis_reg, axis_next;
    logic [tcf_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                      m_valid_reg, m_valid_next;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        axis_next    = axis_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_tready;
        cmd.op       = tcf_pkg::OP_NOP;
        cmd.axis     = axis_reg;
        cmd.iter     = cnt_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = tcf_pkg::OP_LOAD;
                    state_next = S_ACC;
                end
            end
            S_ACC: begin
                cmd.op     = tcf_pkg::OP_ACC;
                axis_next  = 2'd0;
                state_next = S_SQ_INIT;
            end
            S_SQ_INIT: begin
                cmd.op     = tcf_pkg::OP_SQRT_INIT;
                cnt_next   = '0;
                state_next = S_SQ;
            end
            S_SQ: begin
                cmd.op   = tcf_pkg::OP_SQRT_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == SQ_LAST) begin
                    state_next = S_CO_INIT;
                end
            end
            S_CO_INIT: begin
                cmd.op     = tcf_pkg::OP_CORDIC_INIT;
                cnt_next   = '0;
                state_next = S_CO;
            end
            S_CO: begin
                cmd.op   = tcf_pkg::OP_CORDIC_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CO_LAST) begin
                    state_next = S_ANGLE;
                end
            end
            S_ANGLE: begin
                cmd.op = tcf_pkg::OP_ANGLE;
                if (axis_reg == 2'd2) begin
                    axis_next  = 2'd0;
                    state_next = S_BL_MUL;
                end else begin
                    axis_next  = axis_reg + 1'b1;
                    state_next = S_SQ_INIT;
                end
            end
            S_BL_MUL: begin
                cmd.op     = tcf_pkg::OP_BLEND_MUL;
                state_next = S_BL_SUM;
            end
            S_BL_SUM: begin
                cmd.op     = tcf_pkg::OP_BLEND_SUM;
                state_next = S_BL_SAT;
            end
            S_BL_SAT: begin
                cmd.op = tcf_pkg::OP_BLEND_SAT;
                if (axis_reg == 2'd2) begin
                    axis_next  = 2'd0;
                    state_next = S_OUT;
                end else begin
                    axis_next  = axis_reg + 1'b1;
                    state_next = S_BL_MUL;
                end
            end
            S_OUT: begin
                // output register is free or being emptied this cycle
                if (!m_valid_reg || m_tready) begin
                    cmd.op       = tcf_pkg::OP_COMMIT;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            axis_reg    <= 2'd0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            axis_reg    <= axis_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

### rtl/tcf_datapath.sv
// ----------------------------------------------------------------------------
// tcf_datapath
// Sample registers, gyro accumulators, bitwise square root, shared CORDIC,
// blend multiplier, direction logic, config registers and result register.
// ----------------------------------------------------------------------------
module tcf_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  tcf_pkg::cmd_t                     cmd,
    input  logic [95:0]                       s_tdata,
    input  logic                              cfg_we,
    input  logic [1:0]                        cfg_addr,
    input  logic [tcf_pkg::CFG_W-1:0]         cfg_wdata,
    output logic [tcf_pkg::OUT_TDATA_W-1:0]   m_tdata
);

    localparam logic signed [47:0] ACC_MAX = {1'b0, {47{1'b1}}};
    localparam logic signed [47:0] ACC_MIN = {1'b1, {47{1'b0}}};

    // config
    logic [16:0] weight_reg;
    logic [24:0] gain_reg;
    logic [14:0] thr_reg;

    // sample
    logic signed [15:0] ax_reg, ay_reg, az_reg;
    logic [30:0]        sq_reg [3];
    logic signed [41:0] gp_reg [3];
    logic signed [47:0] acc_reg [3];

    // square root
    logic [39:0] rad_reg;
    logic [22:0] rem_reg;
    logic [19:0] root_reg;

    // cordic
    logic signed [39:0] cx_reg, cy_reg;
    logic signed [31:0] cz_reg;
    logic               both_zero_reg, den_zero_reg, neg_reg;

    // blend
    logic signed [14:0] tilt_reg [3];
    logic signed [32:0] pa_reg;
    logic [36:0]        plo_reg;
    logic signed [37:0] phi_reg;
    logic signed [59:0] nsum_reg;
    logic signed [15:0] bl_reg [3];

    logic [2:0]   held_reg;
    logic [103:0] out_reg;

    assign m_tdata = out_reg;

    // ---------------- per-axis operand selection ----------------
    logic signed [15:0] a_sel;
    logic [31:0]        ssum;
    logic [15:0]        a_abs;
    logic [19:0]        mag;
    logic [19:0]        num, den;

    always_comb begin
        case (cmd.axis)
            2'd0:    begin a_sel = ax_reg; ssum = 32'(sq_reg[1]) + 32'(sq_reg[2]); end
            2'd1:    begin a_sel = ay_reg; ssum = 32'(sq_reg[0]) + 32'(sq_reg[2]); end
            default: begin a_sel = az_reg; ssum = 32'(sq_reg[0]) + 32'(sq_reg[1]); end
        endcase
        a_abs = a_sel[15] ? 16'(-{a_sel[15], a_sel}) : a_sel;
        mag   = {a_abs, 4'b0};
        if (cmd.axis == 2'd2) begin
            num = root_reg;
            den = mag;
        end else begin
            num = mag;
            den = root_reg;
        end
    end

    // ---------------- combinational step logic ----------------
    logic signed [15:0] gx, gy, gz;
    logic signed [48:0] acc_sum [3];
    logic [22:0]        rem_sh, trial;
    logic signed [39:0] xs, ys;
    logic signed [31:0] tab_s, zr;
    logic signed [15:0] zq;
    logic [13:0]        ang_mag;
    logic signed [14:0] ang;
    logic [16:0]        wsat, wcomp;
    logic signed [39:0] accs;
    logic signed [59:0] n_full;
    logic signed [27:0] r_full;
    logic signed [15:0] r_sat;
    logic signed [16:0] thr_s, b0, b1;
    logic [2:0]         dir;

    assign gx = s_tdata[63:48];
    assign gy = s_tdata[79:64];
    assign gz = s_tdata[95:80];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            acc_sum[k] = 49'(acc_reg[k]) + 49'(gp_reg[k]);
        end

        rem_sh = {rem_reg[20:0], rad_reg[39:38]};
        trial  = {1'b0, root_reg, 2'b01};

        xs    = cx_reg >>> cmd.iter;
        ys    = cy_reg >>> cmd.iter;
        tab_s = $signed({2'b0, tcf_pkg::atan_entry(cmd.iter)});

        // round half up to hundredths, clamp to 0..9000
        zr = (cz_reg + 32'sd32768) >>> 16;
        zq = zr[15:0];
        if (zq < 0) begin
            ang_mag = 14'd0;
        end else if (zq > 16'sd9000) begin
            ang_mag = 14'd9000;
        end else begin
            ang_mag = zq[13:0];
        end
        if (both_zero_reg) begin
            ang_mag = 14'd0;
        end else if (den_zero_reg) begin
            ang_mag = 14'd9000;
        end
        ang = neg_reg ? -$signed({1'b0, ang_mag}) : $signed({1'b0, ang_mag});

        wsat  = (weight_reg > 17'd65536) ? 17'd65536 : weight_reg;
        wcomp = 17'd65536 - wsat;
        accs  = acc_reg[cmd.axis][47:8];

        n_full = (60'(pa_reg) <<< 16) + (60'(phi_reg) <<< 20)
               + $signed({23'b0, plo_reg}) + 60'sd2147483648;
        r_full = nsum_reg[59:32];
        if (r_full > 28'sd18000) begin
            r_sat = 16'sd18000;
        end else if (r_full < -28'sd18000) begin
            r_sat = -16'sd18000;
        end else begin
            r_sat = r_full[15:0];
        end

        thr_s = $signed({2'b0, thr_reg});
        b0    = 17'(bl_reg[0]);
        b1    = 17'(bl_reg[1]);
        if (b0 < -thr_s) begin
            dir = tcf_pkg::DIR_RIGHT;
        end else if (b0 > thr_s) begin
            dir = tcf_pkg::DIR_LEFT;
        end else if (b1 > thr_s) begin
            dir = tcf_pkg::DIR_UP;
        end else if (b1 < -thr_s) begin
            dir = tcf_pkg::DIR_DOWN;
        end else begin
            dir = held_reg;
        end
    end

    // ---------------- control-bearing state ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            weight_reg <= 17'd62915;
            gain_reg   <= 25'd328;
            thr_reg    <= 15'd2500;
            held_reg   <= tcf_pkg::DIR_NONE;
            for (int k = 0; k < 3; k++) begin
                acc_reg[k] <= '0;
            end
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    tcf_pkg::REG_BLEND_WEIGHT:   weight_reg <= cfg_wdata[16:0];
                    tcf_pkg::REG_GYRO_GAIN:      gain_reg   <= cfg_wdata;
                    tcf_pkg::REG_TILT_THRESHOLD: thr_reg    <= cfg_wdata[14:0];
                    default: ;
                endcase
            end
            if (cmd.op == tcf_pkg::OP_ACC) begin
                for (int k = 0; k < 3; k++) begin
                    if (acc_sum[k] > 49'(ACC_MAX)) begin
                        acc_reg[k] <= ACC_MAX;
                    end else if (acc_sum[k] < 49'(ACC_MIN)) begin
                        acc_reg[k] <= ACC_MIN;
                    end else begin
                        acc_reg[k] <= acc_sum[k][47:0];
                    end
                end
            end
            if (cmd.op == tcf_pkg::OP_COMMIT) begin
                held_reg <= dir;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge aclk) begin
        case (cmd.op)
            tcf_pkg::OP_LOAD: begin
                ax_reg    <= s_tdata[15:0];
                ay_reg    <= s_tdata[31:16];
                az_reg    <= s_tdata[47:32];
                sq_reg[0] <= 31'($signed(s_tdata[15:0]) * $signed(s_tdata[15:0]));
                sq_reg[1] <= 31'($signed(s_tdata[31:16]) * $signed(s_tdata[31:16]));
                sq_reg[2] <= 31'($signed(s_tdata[47:32]) * $signed(s_tdata[47:32]));
                gp_reg[0] <= gx * $signed({1'b0, gain_reg});
                gp_reg[1] <= gy * $signed({1'b0, gain_reg});
                gp_reg[2] <= gz * $signed({1'b0, gain_reg});
            end
            tcf_pkg::OP_SQRT_INIT: begin
                rad_reg  <= {ssum, 8'b0};
                rem_reg  <= '0;
                root_reg <= '0;
            end
            tcf_pkg::OP_SQRT_STEP: begin
                rad_reg <= {rad_reg[37:0], 2'b00};
                if (rem_sh >= trial) begin
                    rem_reg  <= rem_sh - trial;
                    root_reg <= {root_reg[18:0], 1'b1};
                end else begin
                    rem_reg  <= rem_sh;
                    root_reg <= {root_reg[18:0], 1'b0};
                end
            end
            tcf_pkg::OP_CORDIC_INIT: begin
                cx_reg        <= $signed({4'b0, den, 16'b0});
                cy_reg        <= $signed({4'b0, num, 16'b0});
                cz_reg        <= '0;
                both_zero_reg <= (num == '0) && (den == '0);
                den_zero_reg  <= (den == '0);
                neg_reg       <= a_sel[15];
            end
            tcf_pkg::OP_CORDIC_STEP: begin
                if (cy_reg >= 0) begin
                    cx_reg <= cx_reg + ys;
                    cy_reg <= cy_reg - xs;
                    cz_reg <= cz_reg + tab_s;
                end else begin
                    cx_reg <= cx_reg - ys;
                    cy_reg <= cy_reg + xs;
                    cz_reg <= cz_reg - tab_s;
                end
            end
            tcf_pkg::OP_ANGLE: begin
                tilt_reg[cmd.axis] <= ang;
            end
            tcf_pkg::OP_BLEND_MUL: begin
                pa_reg  <= $signed({1'b0, wsat}) * tilt_reg[cmd.axis];
                plo_reg <= wcomp * accs[19:0];
                phi_reg <= $signed({1'b0, wcomp}) * $signed(accs[39:20]);
            end
            tcf_pkg::OP_BLEND_SUM: begin
                nsum_reg <= n_full;
            end
            tcf_pkg::OP_BLEND_SAT: begin
                bl_reg[cmd.axis] <= r_sat;
            end
            tcf_pkg::OP_COMMIT: begin
                out_reg <= {7'b0, (dir != held_reg), dir,
                            bl_reg[2], bl_reg[1], bl_reg[0],
                            tilt_reg[2], tilt_reg[1], tilt_reg[0]};
            end
            default: ;
        endcase
    end

endmodule

### bench/tb_tilt_complementary_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tilt_complementary_filter
// Streams six-axis samples into the tilt filter under random idling and
// back-pressure across several register settings. Each result beat is
// compared field by field with a cycle-free predictor of the angles, gyro
// accumulators, blend and held direction code, or with a typed value.
// ----------------------------------------------------------------------------
module tb_tilt_complementary_filter;

    localparam int CORDIC_STEPS = 16;
    localparam int LATENCY      = 11 + 3 * (23 + CORDIC_STEPS);
    localparam longint ACC_HI   = 64'sh7FFF_FFFF_FFFF;
    localparam longint ACC_LO   = -ACC_HI - 1;
    localparam longint ATAN_TAB [24] = '{
        294912000, 174096719, 91987925, 46694507, 23437865, 11730358,
        5866610, 2933484, 1466764, 733385, 366693, 183346,
        91673, 45837, 22918, 11459, 5730, 2865,
        1432, 716, 358, 179, 90, 45
    };

    typedef struct {
        logic [tcf_pkg::TILT_W-1:0] tilt_x, tilt_y, tilt_z;
        logic [tcf_pkg::ANG_W-1:0]  roll, pitch, yaw;
        logic [tcf_pkg::DIR_W-1:0]  direction;
        logic                       changed;
    } tilt_result_t;

    typedef struct {
        logic [95:0]  sample;
        bit           typed;
        tilt_result_t want;
    } sample_row_t;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic [95:0]                     s_tdata = '0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [tcf_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [1:0]                      cfg_addr = '0;
    logic [tcf_pkg::CFG_W-1:0]       cfg_wdata = '0;

    tilt_complementary_filter #(.CORDIC_STEPS(CORDIC_STEPS)) dut (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // predictor state
    longint unsigned weight_q16, gain_q, thresh_q;
    longint          gyro_acc [3];
    logic [tcf_pkg::DIR_W-1:0] last_dir;

    tilt_result_t expected_q [$];
    int  errors = 0;
    bit  quiet = 1'b0;
    int  hold_off = 0;

    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned res = 0, b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint quadrant_angle(longint num, longint den);
        longint x, y, z, t;
        int steps;
        z = 0;
        if (num == 0 && den == 0) return 0;
        if (den == 0) return 9000;
        steps = CORDIC_STEPS > 24 ? 24 : CORDIC_STEPS;
        x = den * 65536;
        y = num * 65536;
        for (int i = 0; i < steps; i++) begin
            if (y >= 0) begin
                t = x + (y >>> i);
                y = y - (x >>> i);
                z += ATAN_TAB[i];
            end else begin
                t = x - (y >>> i);
                y = y + (x >>> i);
                z -= ATAN_TAB[i];
            end
            x = t;
        end
        z = (z + 32768) >>> 16;
        if (z < 0) z = 0;
        if (z > 9000) z = 9000;
        return z;
    endfunction

    function automatic longint blend_angle(longint ang, longint acc);
        longint w, n, r;
        w = weight_q16 > 65536 ? 65536 : longint'(weight_q16);
        n = w * ang * 65536 + (65536 - w) * (acc >>> 8);
        r = (n + (64'sd1 <<< 31)) >>> 32;
        if (r > 18000) r = 18000;
        if (r < -18000) r = -18000;
        return r;
    endfunction

    function automatic tilt_result_t predict_tilt(logic [95:0] d);
        longint a [3], g, s, mag [3], sq [3], tilt [3], bl [3], thr;
        tilt_result_t r;
        logic [tcf_pkg::DIR_W-1:0] dir;
        for (int k = 0; k < 3; k++) begin
            a[k] = longint'($signed(d[16*k +: 16]));
            mag[k] = (a[k] < 0 ? -a[k] : a[k]) * 16;
            sq[k] = a[k] * a[k];
            g = longint'($signed(d[16*(k+3) +: 16]));
            s = gyro_acc[k] + g * longint'(gain_q);
            if (s > ACC_HI) s = ACC_HI;
            if (s < ACC_LO) s = ACC_LO;
            gyro_acc[k] = s;
        end
        tilt[0] = quadrant_angle(mag[0], floor_root((sq[1] + sq[2]) * 256));
        tilt[1] = quadrant_angle(mag[1], floor_root((sq[0] + sq[2]) * 256));
        tilt[2] = quadrant_angle(floor_root((sq[0] + sq[1]) * 256), mag[2]);
        for (int k = 0; k < 3; k++) begin
            if (a[k] < 0) tilt[k] = -tilt[k];
            bl[k] = blend_angle(tilt[k], gyro_acc[k]);
        end
        thr = longint'(thresh_q);
        dir = last_dir;
        if (bl[0] < -thr) dir = tcf_pkg::DIR_RIGHT;
        else if (bl[0] > thr) dir = tcf_pkg::DIR_LEFT;
        else if (bl[1] > thr) dir = tcf_pkg::DIR_UP;
        else if (bl[1] < -thr) dir = tcf_pkg::DIR_DOWN;
        r.tilt_x = tilt[0][tcf_pkg::TILT_W-1:0];
        r.tilt_y = tilt[1][tcf_pkg::TILT_W-1:0];
        r.tilt_z = tilt[2][tcf_pkg::TILT_W-1:0];
        r.roll  = bl[0][tcf_pkg::ANG_W-1:0];
        r.pitch = bl[1][tcf_pkg::ANG_W-1:0];
        r.yaw   = bl[2][tcf_pkg::ANG_W-1:0];
        r.direction = dir;
        r.changed = (dir != last_dir);
        last_dir = dir;
        return r;
    endfunction

    task automatic write_reg(input logic [1:0] idx, input longint unsigned v);
        @(negedge aclk);
        cfg_we = 1'b1;
        cfg_addr = idx;
        cfg_wdata = v[tcf_pkg::CFG_W-1:0];
        @(negedge aclk);
        cfg_we = 1'b0;
        case (idx)
            tcf_pkg::REG_BLEND_WEIGHT:   weight_q16 = v & 64'h1FFFF;
            tcf_pkg::REG_GYRO_GAIN:      gain_q = v & 64'h1FFFFFF;
            tcf_pkg::REG_TILT_THRESHOLD: thresh_q = v & 64'h7FFF;
            default: ;
        endcase
    endtask

    task automatic drain_and_setup(input longint unsigned w, g, t);
        // stop offering, then let every expected beat come back
        @(negedge aclk);
        s_tvalid = 1'b0;
        wait (expected_q.size() == 0);
        repeat (LATENCY / 8) @(posedge aclk);
        write_reg(tcf_pkg::REG_BLEND_WEIGHT, w);
        write_reg(tcf_pkg::REG_GYRO_GAIN, g);
        write_reg(tcf_pkg::REG_TILT_THRESHOLD, t);
    endtask

    task automatic send_sample(input logic [95:0] d, input bit typed,
                               input tilt_result_t want);
        tilt_result_t p;
        int gap;
        @(negedge aclk);
        s_tdata = d;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        p = predict_tilt(d);
        expected_q.push_back(typed ? want : p);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            @(negedge aclk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    // mode 0: full range, 1: small values, 2: gyro pinned high, 3: gyro pinned low
    function automatic logic [95:0] random_sample(int mode);
        logic [95:0] d;
        for (int k = 0; k < 6; k++) begin
            if (mode == 1 || $urandom_range(0, 4) == 0)
                d[16*k +: 16] = 16'($signed($urandom_range(0, 1024)) - 512);
            else
                d[16*k +: 16] = 16'($urandom);
            if ($urandom_range(0, 9) == 0) d[16*k +: 16] = '0;
        end
        if (mode == 2) d[95:48] = {3{16'h7FFF}};
        if (mode == 3) d[95:48] = {3{16'h8000}};
        return d;
    endfunction

    task automatic random_run(input int n, input int mode);
        tilt_result_t none;
        none = '{default: '0};
        for (int i = 0; i < n; i++) send_sample(random_sample(mode), 1'b0, none);
    endtask

    // receiver back-pressure
    initial begin
        int burst = 0;
        forever begin
            @(negedge aclk);
            if (hold_off > 0) begin
                m_tready = 1'b0;
                hold_off--;
            end else if (quiet) begin
                m_tready = 1'b1;
            end else if (burst > 0) begin
                m_tready = 1'b0;
                burst--;
            end else begin
                m_tready = 1'b1;
                if ($urandom_range(0, 3) == 0) burst = $urandom_range(1, 3);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            tilt_result_t got, want;
            got.tilt_x = m_tdata[14:0];
            got.tilt_y = m_tdata[29:15];
            got.tilt_z = m_tdata[44:30];
            got.roll   = m_tdata[60:45];
            got.pitch  = m_tdata[76:61];
            got.yaw    = m_tdata[92:77];
            got.direction = m_tdata[95:93];
            got.changed   = m_tdata[96];
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result beat %h", $time, m_tdata);
                errors++;
            end else begin
                want = expected_q.pop_front();
                if (got.tilt_x !== want.tilt_x) begin
                    $display("%0t: tilt_x exp %0d got %0d", $time,
                             $signed(want.tilt_x), $signed(got.tilt_x));
                    errors++;
                end
                if (got.tilt_y !== want.tilt_y) begin
                    $display("%0t: tilt_y exp %0d got %0d", $time,
                             $signed(want.tilt_y), $signed(got.tilt_y));
                    errors++;
                end
                if (got.tilt_z !== want.tilt_z) begin
                    $display("%0t: tilt_z exp %0d got %0d", $time,
                             $signed(want.tilt_z), $signed(got.tilt_z));
                    errors++;
                end
                if (got.roll !== want.roll) begin
                    $display("%0t: roll exp %0d got %0d", $time,
                             $signed(want.roll), $signed(got.roll));
                    errors++;
                end
                if (got.pitch !== want.pitch) begin
                    $display("%0t: pitch exp %0d got %0d", $time,
                             $signed(want.pitch), $signed(got.pitch));
                    errors++;
                end
                if (got.yaw !== want.yaw) begin
                    $display("%0t: yaw exp %0d got %0d", $time,
                             $signed(want.yaw), $signed(got.yaw));
                    errors++;
                end
                if (got.direction !== want.direction) begin
                    $display("%0t: direction exp %0d got %0d", $time,
                             want.direction, got.direction);
                    errors++;
                end
                if (got.changed !== want.changed) begin
                    $display("%0t: direction_changed exp %0d got %0d", $time,
                             want.changed, got.changed);
                    errors++;
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

    initial begin
        sample_row_t rows [$];
        sample_row_t row;
        weight_q16 = 62915;
        gain_q = 328;
        thresh_q = 2500;
        gyro_acc = '{0, 0, 0};
        last_dir = tcf_pkg::DIR_NONE;

        // gz, gy, gx, az, ay, ax
        row.typed = 1'b0;
        row.want = '{default: '0};
        rows.push_back('{96'h0, 1'b1, '{default: '0}});  // all zero after reset
        row.sample = {48'h0, 16'h0, 16'h0, 16'h7FFF}; rows.push_back(row);
        row.sample = {48'h0, 16'h0, 16'h0, 16'h8000}; rows.push_back(row);
        row.sample = {48'h0, 16'h0, 16'h7FFF, 16'h0}; rows.push_back(row);
        row.sample = {48'h0, 16'h0, 16'h8000, 16'h0}; rows.push_back(row);
        row.sample = {48'h0, 16'h7FFF, 16'h0, 16'h0}; rows.push_back(row);
        row.sample = {48'h0, 16'h8000, 16'h0, 16'h0}; rows.push_back(row);
        // z zero with x and y set: tilt_z is +90
        row.sample = {48'h0, 16'h0, 16'hFF00, 16'h0100}; rows.push_back(row);
        row.sample = {48'h0, 16'h0100, 16'h0100, 16'h0100}; rows.push_back(row);
        row.sample = {48'h0, 16'h0100, 16'hFF00, 16'hFF00}; rows.push_back(row);
        row.sample = {96'h7FFF_7FFF_7FFF_7FFF_7FFF_7FFF}; rows.push_back(row);
        row.sample = {96'h8000_8000_8000_8000_8000_8000}; rows.push_back(row);
        row.sample = {48'h8000_7FFF_8000, 16'h0100, 16'h0, 16'hE000}; rows.push_back(row);
        row.sample = {48'h0, 16'h0100, 16'h0, 16'h2000}; rows.push_back(row);
        row.sample = {48'h0, 16'h0100, 16'h2000, 16'h0}; rows.push_back(row);
        row.sample = {48'h0, 16'h0100, 16'hE000, 16'h0}; rows.push_back(row);
        row.sample = {48'h0, 16'h0001, 16'h0, 16'h0}; rows.push_back(row);

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (rows[i]) send_sample(rows[i].sample, rows[i].typed, rows[i].want);

        drain_and_setup(62915, 328, 2500);
        for (int i = 0; i < 150; i++) begin
            if (i == 30) hold_off = 400;  // fill the block and stall its input
            send_sample(random_sample($urandom_range(0, 1)), 1'b0, row.want);
        end
        // largest gain: drive the accumulators into saturation
        drain_and_setup(0, 25'h1FFFFFF, 0);
        random_run(160, 2);
        drain_and_setup(65536, 0, 18000);
        random_run(120, 0);
        // weight above one, threshold never reached, saturate low
        drain_and_setup(131071, 25'h1FFFFFF, 32767);
        random_run(300, 3);
        drain_and_setup($urandom_range(0, 65536), $urandom_range(0, 4096),
                        $urandom_range(0, 6000));
        random_run(150, 0);
        drain_and_setup(62915, $urandom_range(0, 2000), $urandom_range(500, 4000));
        quiet = 1'b1;
        random_run(100, 1);
        @(negedge aclk);
        s_tvalid = 1'b0;

        wait (expected_q.size() == 0);
        repeat (LATENCY + 20) @(posedge aclk);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
